/* design/iou_pkg.sv */
// Shared types and constants for the static object tracker.
// No dependencies.
package iou_pkg;

   localparam int COORD_W = 10;

   localparam logic [2:0] KIND_FILTERED = 3'd0;
   localparam logic [2:0] KIND_UPDATED  = 3'd1;
   localparam logic [2:0] KIND_CREATED  = 3'd2;
   localparam logic [2:0] KIND_DROPPED  = 3'd3;
   localparam logic [2:0] KIND_REPORT   = 3'd4;
   localparam logic [2:0] KIND_EMPTY    = 3'd5;

   localparam logic [2:0] CSR_MIN_AREA   = 3'd0;
   localparam logic [2:0] CSR_MOTION_DIV = 3'd1;
   localparam logic [2:0] CSR_MATCH_NUM  = 3'd2;
   localparam logic [2:0] CSR_MATCH_DEN  = 3'd3;
   localparam logic [2:0] CSR_ALERT      = 3'd4;

   typedef struct packed {
      logic        action;
      logic [9:0]  det_x_min;
      logic [9:0]  det_x_max;
      logic [9:0]  det_y_min;
      logic [9:0]  det_y_max;
      logic [19:0] moving_pixels;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] object_id;
      logic [9:0]  obj_x_min;
      logic [9:0]  obj_x_max;
      logic [9:0]  obj_y_min;
      logic [9:0]  obj_y_max;
      logic [15:0] static_frames;
      logic        alert;
      logic        last;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture request, start area multiply
      logic filt_eval;  // register filter decision
      logic scan_clr;   // reset best-match search
      logic scan_ovl;   // stage 1: overlap and union for entry at scan index
      logic scan_cmp;   // stage 2: compare cross products
      logic thr_eval;   // threshold multiply compare
      logic do_update;
      logic do_create;
      logic cmp_step;   // frame-end compaction step
      logic cmp_done;   // commit compaction count
      logic rep_step;   // emit report at scan index
   } cmd_type;

   typedef struct packed {
      logic is_frame_end;
      logic filtered;
      logic found;
      logic matched;
      logic table_full;
   } sts_type;

endpackage

/* design/iou_ctrl.sv */
// Sequencer for the tracker: walks the entry table per request.
// Depends on iou_pkg.
module iou_ctrl
   import iou_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  sts_type sts,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0] count,
   output cmd_type cmd,
   output logic [$clog2(TABLE_DEPTH+1)-1:0] idx,
   output logic emit_single
);
   localparam int CW = $clog2(TABLE_DEPTH+1);
   localparam logic [3:0] S_IDLE = 4'd0, S_AREA = 4'd1, S_FILT = 4'd2,
      S_OVL = 4'd3, S_CMP = 4'd4, S_THR = 4'd5, S_DEC = 4'd6,
      S_COMPACT = 4'd7, S_COMMIT = 4'd8, S_REPORT = 4'd9, S_EMPTY = 4'd10,
      S_FILTOUT = 4'd11, S_DRAIN = 4'd12, S_CHK = 4'd13;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;

   assign busy = (state_ff != S_IDLE);
   assign idx  = idx_ff;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      cmd         = '0;
      emit_single = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = S_AREA;
            end
         end
         S_AREA: begin
            // area and motion product register at the end of this cycle
            if (sts.is_frame_end) begin
               state_in = S_COMPACT;
            end else begin
               state_in = S_FILT;
            end
         end
         S_FILT: begin
            cmd.filt_eval = 1'b1;
            state_in      = S_CHK;
         end
         S_CHK: begin
            cmd.scan_clr = 1'b1;
            state_in = sts.filtered ? S_FILTOUT : S_OVL;
         end
         S_FILTOUT: begin
            emit_single = 1'b1;
            state_in    = S_IDLE;
         end
         S_OVL: begin
            if (idx_ff >= count) begin
               state_in = S_DRAIN;
            end else begin
               cmd.scan_ovl = 1'b1;
               idx_in       = idx_ff + 1'b1;
               state_in     = S_CMP;
            end
         end
         S_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = S_OVL;
         end
         S_DRAIN: begin
            cmd.thr_eval = 1'b1;
            state_in     = S_THR;
         end
         S_THR: begin
            state_in = S_DEC;
         end
         S_DEC: begin
            if (sts.found && sts.matched) cmd.do_update = 1'b1;
            else if (!sts.table_full)     cmd.do_create = 1'b1;
            emit_single = 1'b1;
            state_in    = S_IDLE;
         end
         S_COMPACT: begin
            if (idx_ff >= count) begin
               state_in = S_COMMIT;
            end else begin
               cmd.cmp_step = 1'b1;
               idx_in       = idx_ff + 1'b1;
            end
         end
         S_COMMIT: begin
            cmd.cmp_done = 1'b1;
            idx_in       = '0;
            state_in     = S_REPORT;
         end
         S_REPORT: begin
            if (count == '0) begin
               state_in = S_EMPTY;
            end else begin
               cmd.rep_step = 1'b1;
               idx_in       = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == count) state_in = S_IDLE;
            end
         end
         S_EMPTY: begin
            emit_single = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end
endmodule

/* design/iou_dpath.sv */
// Datapath: config registers, entry table, IoU arithmetic, result register.
// Depends on iou_pkg.
module iou_dpath
   import iou_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int COORD_BITS  = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic [2:0] csr_index,
   input  logic [19:0] csr_data,
   input  req_type req_data,
   input  cmd_type cmd,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0] idx,
   input  logic emit_single,
   output sts_type sts,
   output logic [$clog2(TABLE_DEPTH+1)-1:0] count,
   output logic rsp_valid,
   output rsp_type rsp_data
);
   localparam int CW = $clog2(TABLE_DEPTH+1);
   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int AW = 2 * COORD_BITS;
   localparam int UW = AW + 1;
   localparam int PW = AW + UW;

   typedef struct packed {
      logic [COORD_BITS-1:0] x0, x1, y0, y1;
   } box_type;

   // configuration
   logic [19:0] min_area_ff;
   logic [9:0]  motion_div_ff;
   logic [7:0]  match_num_ff, match_den_ff;
   logic [15:0] alert_frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_area_ff     <= 20'd60;
         motion_div_ff   <= 10'd100;
         match_num_ff    <= 8'd4;
         match_den_ff    <= 8'd5;
         alert_frames_ff <= 16'd60;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_AREA:   min_area_ff     <= csr_data;
            CSR_MOTION_DIV: motion_div_ff   <= csr_data[9:0];
            CSR_MATCH_NUM:  match_num_ff    <= csr_data[7:0];
            CSR_MATCH_DEN:  match_den_ff    <= csr_data[7:0];
            CSR_ALERT:      alert_frames_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   function automatic logic [COORD_BITS-1:0] side_f(
      input logic [COORD_BITS-1:0] lo, input logic [COORD_BITS-1:0] hi);
      side_f = (hi > lo) ? hi - lo : '0;
   endfunction

   // entry table
   logic [TABLE_DEPTH-1:0] seen_ff;
   logic [15:0]   id_mem     [TABLE_DEPTH];
   box_type       box_mem    [TABLE_DEPTH];
   logic [15:0]   static_mem [TABLE_DEPTH];
   logic [CW-1:0] count_ff, wr_ff;
   logic [15:0]   next_id_ff;

   assign count = count_ff;

   // request capture
   logic          frame_end_ff;
   box_type       det_ff;
   logic [19:0]   mov_ff;
   logic [AW-1:0] area_ff;
   logic [29:0]   mov_prod_ff;
   logic          filt_ff;

   logic [IW-1:0] ridx;
   assign ridx = idx[IW-1:0];

   // scan stage 1
   box_type       eb;
   logic [COORD_BITS-1:0] ix0, ix1, iy0, iy1;
   logic [AW-1:0] ovl_ff;
   logic [UW-1:0] uni_ff;
   logic [IW-1:0] cand_ff;
   always_comb begin
      eb  = box_mem[ridx];
      ix0 = (det_ff.x0 > eb.x0) ? det_ff.x0 : eb.x0;
      ix1 = (det_ff.x1 < eb.x1) ? det_ff.x1 : eb.x1;
      iy0 = (det_ff.y0 > eb.y0) ? det_ff.y0 : eb.y0;
      iy1 = (det_ff.y1 < eb.y1) ? det_ff.y1 : eb.y1;
   end
   logic [AW-1:0] ovl_c, earea_c;
   assign ovl_c   = side_f(ix0, ix1) * side_f(iy0, iy1);
   assign earea_c = side_f(eb.x0, eb.x1) * side_f(eb.y0, eb.y1);

   // best tracking
   logic          found_ff;
   logic [IW-1:0] best_ff;
   logic [AW-1:0] best_i_ff;
   logic [UW-1:0] best_u_ff;
   logic [PW-1:0] lhs_c, rhs_c;
   assign lhs_c = PW'(ovl_ff) * PW'(best_u_ff);
   assign rhs_c = PW'(best_i_ff) * PW'(uni_ff);

   logic matched_ff;
   logic [AW+7:0] thr_l;
   logic [UW+7:0] thr_r;
   assign thr_l = (AW+8)'(best_i_ff) * (AW+8)'(match_den_ff);
   assign thr_r = (UW+8)'(match_num_ff) * (UW+8)'(best_u_ff);

   assign sts.is_frame_end = frame_end_ff;
   assign sts.filtered     = filt_ff;
   assign sts.found        = found_ff;
   assign sts.matched      = matched_ff;
   assign sts.table_full   = (count_ff >= CW'(TABLE_DEPTH));

   logic [15:0] upd_static;
   assign upd_static = (static_mem[best_ff] == 16'hFFFF) ? 16'hFFFF
                                                         : static_mem[best_ff] + 16'd1;

   logic [IW-1:0] wr_idx;
   assign wr_idx = wr_ff[IW-1:0];
   logic [IW-1:0] cnt_idx;
   assign cnt_idx = count_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         frame_end_ff <= req_data.action;
         det_ff.x0    <= req_data.det_x_min[COORD_BITS-1:0];
         det_ff.x1    <= req_data.det_x_max[COORD_BITS-1:0];
         det_ff.y0    <= req_data.det_y_min[COORD_BITS-1:0];
         det_ff.y1    <= req_data.det_y_max[COORD_BITS-1:0];
         mov_ff       <= req_data.moving_pixels;
      end
      area_ff     <= side_f(det_ff.x0, det_ff.x1) * side_f(det_ff.y0, det_ff.y1);
      mov_prod_ff <= mov_ff * motion_div_ff;
      if (cmd.filt_eval)
         filt_ff <= !(32'(area_ff) > 32'(min_area_ff)) ||
                    (32'(mov_prod_ff) > 32'(area_ff));
      if (cmd.scan_ovl) begin
         ovl_ff  <= ovl_c;
         uni_ff  <= UW'(area_ff) + UW'(earea_c) - UW'(ovl_c);
         cand_ff <= ridx;
      end
      if (cmd.scan_cmp && ovl_ff != '0 && (!found_ff || lhs_c > rhs_c)) begin
         best_ff   <= cand_ff;
         best_i_ff <= ovl_ff;
         best_u_ff <= uni_ff;
      end
      if (cmd.thr_eval) matched_ff <= (UW+8)'(thr_l) >= thr_r;
      if (cmd.do_update) begin
         box_mem[best_ff]    <= det_ff;
         static_mem[best_ff] <= upd_static;
      end
      if (cmd.do_create) begin
         box_mem[cnt_idx]    <= det_ff;
         static_mem[cnt_idx] <= 16'd0;
         id_mem[cnt_idx]     <= next_id_ff + 16'd1;
      end
      if (cmd.cmp_step && seen_ff[ridx]) begin
         box_mem[wr_idx]    <= box_mem[ridx];
         static_mem[wr_idx] <= static_mem[ridx];
         id_mem[wr_idx]     <= id_mem[ridx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         count_ff   <= '0;
         wr_ff      <= '0;
         next_id_ff <= '0;
         found_ff   <= 1'b0;
      end else begin
         if (cmd.load) wr_ff <= '0;
         if (cmd.scan_clr) found_ff <= 1'b0;
         if (cmd.scan_cmp && ovl_ff != '0) found_ff <= 1'b1;
         if (cmd.do_update) seen_ff[best_ff] <= 1'b1;
         if (cmd.do_create) begin
            seen_ff[cnt_idx] <= 1'b1;
            count_ff         <= count_ff + 1'b1;
            next_id_ff       <= next_id_ff + 16'd1;
         end
         if (cmd.cmp_step && seen_ff[ridx]) wr_ff <= wr_ff + 1'b1;
         if (cmd.cmp_done) begin
            count_ff <= wr_ff;
            seen_ff  <= '0;
         end
      end
   end

   // result register
   rsp_type out_c;
   logic    out_v;
   always_comb begin
      out_c = '0;
      out_v = 1'b0;
      out_c.last = 1'b1;
      out_c.obj_x_min = 10'(det_ff.x0);
      out_c.obj_x_max = 10'(det_ff.x1);
      out_c.obj_y_min = 10'(det_ff.y0);
      out_c.obj_y_max = 10'(det_ff.y1);
      if (emit_single) begin
         out_v = 1'b1;
         if (frame_end_ff) begin
            out_c = '0;
            out_c.kind = KIND_EMPTY;
            out_c.last = 1'b1;
         end else if (filt_ff) begin
            out_c.kind = KIND_FILTERED;
         end else if (found_ff && matched_ff) begin
            out_c.kind          = KIND_UPDATED;
            out_c.object_id     = id_mem[best_ff];
            out_c.static_frames = upd_static;
            out_c.alert         = upd_static > alert_frames_ff;
         end else if (sts.table_full) begin
            out_c.kind = KIND_DROPPED;
         end else begin
            out_c.kind      = KIND_CREATED;
            out_c.object_id = next_id_ff + 16'd1;
         end
      end else if (cmd.rep_step) begin
         out_v               = 1'b1;
         out_c.kind          = KIND_REPORT;
         out_c.object_id     = id_mem[ridx];
         out_c.obj_x_min     = 10'(box_mem[ridx].x0);
         out_c.obj_x_max     = 10'(box_mem[ridx].x1);
         out_c.obj_y_min     = 10'(box_mem[ridx].y0);
         out_c.obj_y_max     = 10'(box_mem[ridx].y1);
         out_c.static_frames = static_mem[ridx];
         out_c.alert         = static_mem[ridx] > alert_frames_ff;
         out_c.last          = (idx + 1'b1 == count_ff);
      end
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= out_v;
      rsp_data_ff <= out_c;
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

/* design/iou_static_object_tracker.sv */
// Top level of the static object tracker: sequencer plus datapath.
// Depends on iou_pkg, iou_ctrl, iou_dpath.
//
// Operation: a request (start while busy is low) is either a detection box
// (action 0) or an end of frame (action 1). A detection yields one result.
// The sequencer walks the entry table one entry after another, each entry
// going through an overlap/union stage and then a cross-product compare.
// An end of frame compacts the table one entry per cycle and then emits one
// report per survivor on consecutive cycles, or a single frame-empty result.
// Each result is shown for one cycle with rsp_valid; the receiver cannot
// stall, so it must take every transfer. busy stays high until the last
// result of a request is registered. Configuration writes are accepted at
// any time (csr_ready is tied high) but are meant to be made only while the
// block is idle.
module iou_static_object_tracker
   import iou_pkg::*;
#(
   parameter int TABLE_DEPTH = 16,
   parameter int COORD_BITS  = 10
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  req_type req_data,
   output logic rsp_valid,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [19:0] csr_data
);
   localparam int CW = $clog2(TABLE_DEPTH+1);

   cmd_type cmd;
   sts_type sts;
   logic [CW-1:0] idx, count;
   logic emit_single;

   assign csr_ready = 1'b1;

   iou_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock, .reset, .start, .busy, .sts, .count, .cmd, .idx, .emit_single
   );

   iou_dpath #(.TABLE_DEPTH(TABLE_DEPTH), .COORD_BITS(COORD_BITS)) u_dpath (
      .clock, .reset, .csr_valid, .csr_index, .csr_data, .req_data, .cmd,
      .idx, .emit_single, .sts, .count, .rsp_valid, .rsp_data
   );
endmodule
